>>> src/c3bp_pkg.sv
// Shared constants, types and register codes of the 3x3 convolution block.
package c3bp_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;
  localparam int ROW_BITS       = HEIGHT_BITS + 1;
  localparam int SAMPLE_BITS    = 16;
  localparam int WROW_BITS      = 3 * SAMPLE_BITS;
  localparam int PROD_BITS      = 2 * SAMPLE_BITS;
  localparam int SUM_BITS       = 35;
  localparam int NPROD_BITS     = SUM_BITS + SAMPLE_BITS;
  localparam int POS_SHIFT      = 13;
  localparam int NEG_SHIFT      = 26;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int APB_ADDR_BITS  = 6;
  localparam int APB_DATA_BITS  = 64;
  localparam int LINE_BITS      = 2 * SAMPLE_BITS;

  localparam logic [2:0] REG_W_TOP  = 3'd0;
  localparam logic [2:0] REG_W_MID  = 3'd1;
  localparam logic [2:0] REG_W_BOT  = 3'd2;
  localparam logic [2:0] REG_BIAS   = 3'd3;
  localparam logic [2:0] REG_SLOPE  = 3'd4;
  localparam logic [2:0] REG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [NPROD_BITS-1:0]  nprod_t;

  localparam smp_t SMP_MAX = 16'sh7FFF;
  localparam smp_t SMP_MIN = 16'sh8000;

  // one 3x3 neighborhood, padding already zeroed; tap[row][col], col 0 is left
  typedef struct packed {
    smp_t [2:0][2:0] tap;
    logic            last;
  } tap_item_t;

  typedef struct packed {
    logic [WROW_BITS-1:0] w_top;
    logic [WROW_BITS-1:0] w_mid;
    logic [WROW_BITS-1:0] w_bot;
    smp_t                 bias;
    smp_t                 slope;
  } coef_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  width;
    logic [HEIGHT_BITS-1:0] height;
    logic                   restart;
  } geom_t;

endpackage

>>> src/c3bp_ifs.sv
// Stream channel interfaces: pixel input and activation output.
interface c3bp_pixel_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic signed [c3bp_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface c3bp_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [c3bp_pkg::SAMPLE_BITS-1:0] activation;
  logic                                  frame_last;

  modport source (output valid, activation, frame_last, input ready);
  modport sink (input valid, activation, frame_last, output ready);
endinterface

>>> src/c3bp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c3bp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/c3bp_front.sv
// Front end: raster position tracking, line stores, 3x3 window and tap classification.
module c3bp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  c3bp_pkg::geom_t       geom,
  c3bp_pixel_if.sink            pixel,
  output logic                  q_valid,
  input  logic                  q_ready,
  output c3bp_pkg::tap_item_t   q_item
);

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_ROWEND = 2'd1;  // last column of a row, window before shift
  localparam logic [1:0] KIND_BODY   = 2'd2;  // any column but the last, window after shift

  logic [c3bp_pkg::COL_BITS-1:0]   col;
  logic [c3bp_pkg::ROW_BITS-1:0]   row;
  logic [c3bp_pkg::WIDTH_BITS-1:0] col_inc;
  logic [c3bp_pkg::ROW_BITS-1:0]   height_x;
  logic [c3bp_pkg::ROW_BITS-1:0]   row_m1;
  logic [c3bp_pkg::ROW_BITS-1:0]   row_m2;
  logic [c3bp_pkg::ROW_BITS-1:0]   rr;
  logic                            at_rowend;
  logic                            in_body;
  logic                            frame_end;
  logic                            left_ok;
  logic                            zero_in;
  logic                            accept;

  logic                                 s1_valid;
  logic                                 s1_adv;
  c3bp_pkg::smp_t                       s1_v;
  logic [c3bp_pkg::COL_BITS-1:0]        s1_col;
  logic [1:0]                           s1_kind;
  logic                                 s1_left;
  logic                                 s1_top;
  logic                                 s1_bot;
  logic                                 s1_last;
  logic                                 s1_fwd;
  logic [c3bp_pkg::LINE_BITS-1:0]       s1_fwd_data;

  logic [c3bp_pkg::LINE_BITS-1:0]       ram_q;
  logic [c3bp_pkg::LINE_BITS-1:0]       line_pair;
  logic [c3bp_pkg::LINE_BITS-1:0]       wr_data;
  c3bp_pkg::smp_t                       up;
  c3bp_pkg::smp_t                       lo;

  c3bp_pkg::smp_t [2:0][2:0]            win;
  c3bp_pkg::smp_t [2:0][2:0]            win_next;
  c3bp_pkg::tap_item_t                  taps;

  assign accept      = pixel.valid && pixel.ready;
  assign s1_adv      = s1_valid && ((s1_kind == KIND_NONE) || q_ready);
  assign pixel.ready = !s1_valid || s1_adv;

  // classification of the item at the current raster position
  always_comb begin
    height_x  = {1'b0, geom.height};
    row_m1    = row - c3bp_pkg::ROW_BITS'(1);
    row_m2    = row - c3bp_pkg::ROW_BITS'(2);
    col_inc   = {1'b0, col} + c3bp_pkg::WIDTH_BITS'(1);
    at_rowend = (col == '0) && (row >= c3bp_pkg::ROW_BITS'(2)) && (row_m2 < height_x);
    in_body   = (col != '0) && (row != '0) && (row_m1 < height_x);
    rr        = at_rowend ? row_m2 : row_m1;
    frame_end = at_rowend && ((row_m2 + c3bp_pkg::ROW_BITS'(1)) == height_x);
    left_ok   = at_rowend ? (geom.width >= c3bp_pkg::WIDTH_BITS'(2))
                          : (col >= c3bp_pkg::COL_BITS'(2));
    zero_in   = pixel.cmd || (row >= height_x);
  end

  always_ff @(posedge clk) begin
    if (rst || geom.restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col_inc == geom.width) begin
        col <= '0;
        row <= row + c3bp_pkg::ROW_BITS'(1);
      end else begin
        col <= col_inc[c3bp_pkg::COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v        <= zero_in ? '0 : pixel.sample;
      s1_col      <= col;
      s1_kind     <= at_rowend ? KIND_ROWEND : (in_body ? KIND_BODY : KIND_NONE);
      s1_left     <= left_ok;
      s1_top      <= rr != '0;
      s1_bot      <= (rr + c3bp_pkg::ROW_BITS'(1)) < height_x;
      s1_last     <= frame_end;
      // the stage ahead writes this column at the same edge: take its data
      s1_fwd      <= s1_adv && (s1_col == col);
      s1_fwd_data <= wr_data;
    end
  end

  // entry holds {upper, lower}; upper takes the old lower, lower takes the new sample
  c3bp_ram #(
    .WIDTH (c3bp_pkg::LINE_BITS),
    .DEPTH (c3bp_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col),
    .rdata (ram_q)
  );

  always_comb begin
    line_pair = s1_fwd ? s1_fwd_data : ram_q;
    up        = line_pair[c3bp_pkg::LINE_BITS-1:c3bp_pkg::SAMPLE_BITS];
    lo        = line_pair[c3bp_pkg::SAMPLE_BITS-1:0];
    wr_data   = {lo, s1_v};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = up;
    win_next[1][2] = lo;
    win_next[2][2] = s1_v;
  end

  always_ff @(posedge clk) begin
    if (rst || geom.restart) begin
      win <= '0;
    end else if (s1_adv) begin
      win <= s1_last ? '0 : win_next;
    end
  end

  always_comb begin
    taps = '0;
    if (s1_kind == KIND_ROWEND) begin
      for (int i = 0; i < 3; i++) begin
        taps.tap[i][0] = s1_left ? win[i][1] : '0;
        taps.tap[i][1] = win[i][2];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        taps.tap[i][0] = s1_left ? win_next[i][0] : '0;
        taps.tap[i][1] = win_next[i][1];
        taps.tap[i][2] = win_next[i][2];
      end
    end
    if (!s1_top) begin
      taps.tap[0] = '0;
    end
    if (!s1_bot) begin
      taps.tap[2] = '0;
    end
    taps.last = s1_last;
  end

  assign q_valid = s1_valid && (s1_kind != KIND_NONE);
  assign q_item  = taps;

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col} < geom.width))
    else $error("column counter outside the row");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_col) && $stable(s1_kind)))
    else $error("stalled line-store stage lost its item");

endmodule

>>> src/c3bp_queue.sv
// Short queue of tap neighborhoods between the front end and the arithmetic.
module c3bp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  c3bp_pkg::tap_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output c3bp_pkg::tap_item_t pop_item
);

  c3bp_pkg::tap_item_t                   slots [c3bp_pkg::QUEUE_DEPTH];
  logic [c3bp_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [c3bp_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [c3bp_pkg::QUEUE_PTR_BITS:0]     count;
  logic                                  do_push;
  logic                                  do_pop;

  assign push_ready = count != (c3bp_pkg::QUEUE_PTR_BITS + 1)'(c3bp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{c3bp_pkg::QUEUE_PTR_BITS{1'b0}}, do_push}
                     - {{c3bp_pkg::QUEUE_PTR_BITS{1'b0}}, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= (c3bp_pkg::QUEUE_PTR_BITS + 1)'(c3bp_pkg::QUEUE_DEPTH)))
    else $error("queue fill count beyond depth");

endmodule

>>> src/c3bp_back.sv
// Back end: nine products, bias add, rounding, PReLU and saturation, output register.
module c3bp_back (
  input  logic                clk,
  input  logic                rst,
  input  c3bp_pkg::coef_t     coef,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  c3bp_pkg::tap_item_t pop_item,
  c3bp_result_if.source       result
);

  localparam int POS_BITS = c3bp_pkg::SUM_BITS - c3bp_pkg::POS_SHIFT;
  localparam int NSH_BITS = c3bp_pkg::NPROD_BITS - c3bp_pkg::NEG_SHIFT;

  logic                   en;
  c3bp_pkg::smp_t         wt [3][3];
  c3bp_pkg::sum_t         bias_term;

  logic                   v1, v2, v3, v4;
  logic                   last1, last2, last3, last4;
  c3bp_pkg::prod_t        p [3][3];
  c3bp_pkg::sum_t         ps [3];
  c3bp_pkg::sum_t         sum3;
  c3bp_pkg::sum_t         pos_rnd;
  logic                   neg4;
  logic [POS_BITS-1:0]    pos4;
  c3bp_pkg::nprod_t       nprod4;
  c3bp_pkg::nprod_t       nround;
  logic [NSH_BITS-1:0]    nshift;
  c3bp_pkg::smp_t         act;

  // whole pipe holds while a finished result waits
  assign en        = !result.valid || result.ready;
  assign pop_ready = en;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wt[0][j] = coef.w_top[j*c3bp_pkg::SAMPLE_BITS +: c3bp_pkg::SAMPLE_BITS];
      wt[1][j] = coef.w_mid[j*c3bp_pkg::SAMPLE_BITS +: c3bp_pkg::SAMPLE_BITS];
      wt[2][j] = coef.w_bot[j*c3bp_pkg::SAMPLE_BITS +: c3bp_pkg::SAMPLE_BITS];
    end
    bias_term = {{(c3bp_pkg::SUM_BITS - c3bp_pkg::SAMPLE_BITS - c3bp_pkg::POS_SHIFT)
                  {coef.bias[c3bp_pkg::SAMPLE_BITS-1]}},
                 coef.bias, {c3bp_pkg::POS_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      v1           <= pop_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result.valid <= v4;
    end
  end

  always_comb begin
    pos_rnd = sum3 + c3bp_pkg::sum_t'(1 << (c3bp_pkg::POS_SHIFT - 1));
    nround  = nprod4 + (c3bp_pkg::nprod_t'(1) <<< (c3bp_pkg::NEG_SHIFT - 1));
    nshift  = nround[c3bp_pkg::NPROD_BITS-1:c3bp_pkg::NEG_SHIFT];
    if (neg4) begin
      // fits when every bit above the sign position matches it
      if ((&nshift[NSH_BITS-1:c3bp_pkg::SAMPLE_BITS-1]) ||
          !(|nshift[NSH_BITS-1:c3bp_pkg::SAMPLE_BITS-1])) begin
        act = nshift[c3bp_pkg::SAMPLE_BITS-1:0];
      end else begin
        act = nshift[NSH_BITS-1] ? c3bp_pkg::SMP_MIN : c3bp_pkg::SMP_MAX;
      end
    end else begin
      if (|pos4[POS_BITS-1:c3bp_pkg::SAMPLE_BITS-1]) begin
        act = c3bp_pkg::SMP_MAX;
      end else begin
        act = pos4[c3bp_pkg::SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] <= $signed(pop_item.tap[i][j]) * wt[i][j];
        end
      end
      last1 <= pop_item.last;

      for (int i = 0; i < 3; i++) begin
        ps[i] <= c3bp_pkg::sum_t'(p[i][0]) + c3bp_pkg::sum_t'(p[i][1])
               + c3bp_pkg::sum_t'(p[i][2]) + ((i == 0) ? bias_term : '0);
      end
      last2 <= last1;

      sum3  <= ps[0] + ps[1] + ps[2];
      last3 <= last2;

      neg4   <= sum3[c3bp_pkg::SUM_BITS-1];
      pos4   <= pos_rnd[c3bp_pkg::SUM_BITS-1:c3bp_pkg::POS_SHIFT];
      nprod4 <= sum3 * coef.slope;
      last4  <= last3;

      result.activation <= act;
      result.frame_last <= last4;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (v4 && en) |=> result.valid)
    else $error("finished sum did not reach the output register");

endmodule

>>> src/conv3x3_bias_prelu.sv
// Top level: register port, front end, tap queue and arithmetic back end.
//
//  channel   role       handshake           payload
//  pixel     item in    valid/ready         cmd, sample
//  result    item out   valid/ready         activation, frame_last
//  APB       registers  psel/penable/pready weights, bias, slope, width, height
//
// One item per clock in steady state, while neither side stalls. A result leaves
// once the item that causes it has passed the line-store read, the tap queue and
// the five stages of multiply, sum, slope multiply and saturation.
// Reset clears counters, window and queue; line stores are not cleared, their
// stale entries only ever reach padded (zeroed) taps.
// Either side may stall; the queue lets the front run while results wait.
module conv3x3_bias_prelu (
  input  logic                                clk,
  input  logic                                rst,
  c3bp_pixel_if.sink                          pixel,
  c3bp_result_if.source                       result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [c3bp_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [c3bp_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [c3bp_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  c3bp_pkg::coef_t                    coef;
  logic [c3bp_pkg::WIDTH_BITS-1:0]    width;
  logic [c3bp_pkg::HEIGHT_BITS-1:0]   height;
  logic [c3bp_pkg::WIDTH_BITS-1:0]    width_next;
  logic [c3bp_pkg::HEIGHT_BITS-1:0]   height_next;
  logic [2:0]                         reg_idx;
  logic                               wr;
  c3bp_pkg::geom_t                    geom;

  logic                               q_push_valid;
  logic                               q_push_ready;
  c3bp_pkg::tap_item_t                q_push_item;
  logic                               q_pop_valid;
  logic                               q_pop_ready;
  c3bp_pkg::tap_item_t                q_pop_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[c3bp_pkg::APB_ADDR_BITS-1:3];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    width_next = pwdata[c3bp_pkg::WIDTH_BITS-1:0];
    if (width_next == '0) begin
      width_next = c3bp_pkg::WIDTH_BITS'(1);
    end else if (width_next > c3bp_pkg::WIDTH_BITS'(c3bp_pkg::MAX_WIDTH)) begin
      width_next = c3bp_pkg::WIDTH_BITS'(c3bp_pkg::MAX_WIDTH);
    end
    height_next = pwdata[c3bp_pkg::HEIGHT_BITS-1:0];
    if (height_next == '0) begin
      height_next = c3bp_pkg::HEIGHT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef   <= '0;
      width  <= c3bp_pkg::WIDTH_BITS'(1);
      height <= c3bp_pkg::HEIGHT_BITS'(1);
    end else if (wr) begin
      unique case (reg_idx)
        c3bp_pkg::REG_W_TOP:  coef.w_top <= pwdata[c3bp_pkg::WROW_BITS-1:0];
        c3bp_pkg::REG_W_MID:  coef.w_mid <= pwdata[c3bp_pkg::WROW_BITS-1:0];
        c3bp_pkg::REG_W_BOT:  coef.w_bot <= pwdata[c3bp_pkg::WROW_BITS-1:0];
        c3bp_pkg::REG_BIAS:   coef.bias  <= pwdata[c3bp_pkg::SAMPLE_BITS-1:0];
        c3bp_pkg::REG_SLOPE:  coef.slope <= pwdata[c3bp_pkg::SAMPLE_BITS-1:0];
        c3bp_pkg::REG_WIDTH:  width      <= width_next;
        c3bp_pkg::REG_HEIGHT: height     <= height_next;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      c3bp_pkg::REG_W_TOP:  prdata = c3bp_pkg::APB_DATA_BITS'(coef.w_top);
      c3bp_pkg::REG_W_MID:  prdata = c3bp_pkg::APB_DATA_BITS'(coef.w_mid);
      c3bp_pkg::REG_W_BOT:  prdata = c3bp_pkg::APB_DATA_BITS'(coef.w_bot);
      c3bp_pkg::REG_BIAS:   prdata = {{(c3bp_pkg::APB_DATA_BITS - c3bp_pkg::SAMPLE_BITS)
                                       {coef.bias[c3bp_pkg::SAMPLE_BITS-1]}}, coef.bias};
      c3bp_pkg::REG_SLOPE:  prdata = {{(c3bp_pkg::APB_DATA_BITS - c3bp_pkg::SAMPLE_BITS)
                                       {coef.slope[c3bp_pkg::SAMPLE_BITS-1]}}, coef.slope};
      c3bp_pkg::REG_WIDTH:  prdata = c3bp_pkg::APB_DATA_BITS'(width);
      c3bp_pkg::REG_HEIGHT: prdata = c3bp_pkg::APB_DATA_BITS'(height);
      default:              prdata = '0;
    endcase
  end

  // geometry writes restart the frame at the same edge
  always_comb begin
    geom.width   = width;
    geom.height  = height;
    geom.restart = wr && ((reg_idx == c3bp_pkg::REG_WIDTH) ||
                          (reg_idx == c3bp_pkg::REG_HEIGHT));
  end

  c3bp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .pixel   (pixel),
    .q_valid (q_push_valid),
    .q_ready (q_push_ready),
    .q_item  (q_push_item)
  );

  c3bp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  c3bp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_item  (q_pop_item),
    .result    (result)
  );

endmodule
